// ===== src/scq_pkg.sv =====
// Package for the soft clip quantizer: widths, constants and the
// divider stage payload type. No dependencies.
package scq_pkg;

    // Input format and output full scale
    localparam int FRAC_BITS  = 16;
    localparam int IN_W       = 32;
    localparam int OUT_W      = 16;
    localparam int FULL_SCALE = 32767;

    // Magnitude of a 32-bit two's complement value, up to 2^31
    localparam int MAG_W = IN_W;
    // Denominator 1 + |x| in fixed point, and twice it
    localparam int DEN_W = MAG_W;
    localparam int D2_W  = DEN_W + 1;
    // Numerator 2*FULL_SCALE*m + D and the aligned divisor share one width
    localparam int NUM_W = 48;

    // Quotient never exceeds FULL_SCALE
    localparam int Q_W        = 15;
    localparam int BPS        = 3;
    localparam int DIV_STAGES = Q_W / BPS;

    // Payload carried through the divider stages
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [NUM_W-1:0] dvs;
        logic [Q_W-1:0]   quo;
        logic             neg;
        logic             last;
    } t_div_data;

endpackage

// ===== src/scq_div_stage.sv =====
// One pipeline stage of the restoring divider: retires BPS quotient bits.
// Depends on scq_pkg for widths and the stage payload type.
module scq_div_stage
    import scq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_div_data i_data,
    output logic      o_valid,
    output t_div_data o_data
);

    logic      r_valid;
    t_div_data r_data;
    t_div_data n_data;

    // Compare and subtract against the divisor at BPS alignments, high first
    always_comb begin
        logic [NUM_W-1:0] rem;
        logic [NUM_W-1:0] trial;
        logic [BPS-1:0]   bits;
        rem  = i_data.rem;
        bits = '0;
        for (int j = 0; j < BPS; j++) begin
            trial = i_data.dvs << (BPS - 1 - j);
            if (rem >= trial) begin
                rem              = rem - trial;
                bits[BPS-1-j]    = 1'b1;
            end
        end
        n_data      = i_data;
        n_data.rem  = rem;
        n_data.dvs  = i_data.dvs >> BPS;
        n_data.quo  = {i_data.quo[Q_W-BPS-1:0], bits};
    end

    // Valid bit resets; payload does not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== src/soft_clip_quantizer.sv =====
// Pipeline: stage A, stage B, 5 divider stages and the output register, in that order.
// Throughput: one sample per cycle while the output is not stalled; the divider retires
// 3 quotient bits in each of its 5 stages, so the stage count sets the latency.
// Stalls: a low i_m_tready with a valid output freezes the whole pipeline.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
// Top level of the soft clip quantizer. Depends on scq_pkg and scq_div_stage.
module soft_clip_quantizer
    import scq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Input stream
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,   // [31:0] sample_in
    input  logic             i_s_tlast,   // last_in_block
    // Output stream
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,   // [15:0] sample_out
    output logic             o_m_tlast    // last_out
);

    logic en;

    // Stage A: magnitude and sign
    logic             r_a_valid;
    logic [MAG_W-1:0] r_a_mag;
    logic             r_a_neg;
    logic             r_a_last;

    // Stage B: numerator and aligned divisor
    logic             r_b_valid;
    t_div_data        r_b_data;
    logic [DEN_W-1:0] den;
    logic [D2_W-1:0]  den2;
    logic [NUM_W-1:0] num;

    // Divider chain
    logic      div_valid [DIV_STAGES+1];
    t_div_data div_data  [DIV_STAGES+1];

    // Output register
    logic             r_o_valid;
    logic [OUT_W-1:0] r_o_data;
    logic             r_o_last;

    // Whole pipeline advances when the output slot is free or being taken
    assign en         = !r_o_valid || i_m_tready;
    assign o_s_tready = en;

    // Stage A
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_neg  <= i_s_tdata[IN_W-1];
            r_a_mag  <= i_s_tdata[IN_W-1] ? (~i_s_tdata + 1'b1) : i_s_tdata;
            r_a_last <= i_s_tlast;
        end
    end

    // Stage B: D = 2^FRAC_BITS + m, N = 2*FULL_SCALE*m + D, divisor 2D
    assign den  = (DEN_W'(1) << FRAC_BITS) + r_a_mag;
    assign den2 = {den, 1'b0};
    assign num  = ({{(NUM_W-MAG_W){1'b0}}, r_a_mag} << (OUT_W))
                - ({{(NUM_W-MAG_W){1'b0}}, r_a_mag} << 1)
                + {{(NUM_W-DEN_W){1'b0}}, den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_data.rem  <= num;
            r_b_data.dvs  <= {{(NUM_W-D2_W){1'b0}}, den2} << (Q_W - BPS);
            r_b_data.quo  <= '0;
            r_b_data.neg  <= r_a_neg;
            r_b_data.last <= r_a_last;
        end
    end

    assign div_valid[0] = r_b_valid;
    assign div_data[0]  = r_b_data;

    // Divider stages
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        scq_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (div_valid[k]),
            .i_data  (div_data[k]),
            .o_valid (div_valid[k+1]),
            .o_data  (div_data[k+1])
        );
    end

    // Output: apply the sign; magnitude stays at or below full scale
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= div_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_data <= div_data[DIV_STAGES].neg
                      ? (~{1'b0, div_data[DIV_STAGES].quo} + 1'b1)
                      : {1'b0, div_data[DIV_STAGES].quo};
            r_o_last <= div_data[DIV_STAGES].last;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tlast  = r_o_last;

`ifndef SYNTH
    // Output register is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // A stalled result holds its value
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tlast))
        else $error("stalled result changed");

    // Soft clip can never reach -32768 (16'h8000), beyond negative full scale
    a_no_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata != 16'h8000)
        else $error("magnitude exceeded full scale");

    // Input side is ready whenever the sink is ready
    a_ready_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tready |-> o_s_tready)
        else $error("input stalled while sink ready");
`endif

endmodule

// ===== verif/scq_stream_checker.sv =====
// Stream checker for the soft clip quantizer: watches both handshakes,
// predicts each PCM result and compares it with what the block returns.
// Depends on scq_pkg.
`timescale 1ns / 1ps

module scq_stream_checker
    import scq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Input stream, as seen at the block
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,   // [31:0] sample_in
    input  logic             i_s_tlast,   // last_in_block
    // Output stream, as seen at the block
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    input  logic [OUT_W-1:0] i_m_tdata,   // [15:0] sample_out
    input  logic             i_m_tlast,   // last_out
    // Status for the testbench top
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);

    // Only the first few mismatches get a line; all of them are counted
    localparam int MAX_REPORTS = 40;

    // One PCM sample the block still owes, with its source for messages
    typedef struct packed {
        logic [IN_W-1:0]  sample_in;
        logic [OUT_W-1:0] pcm;
        logic             last;
    } t_pcm_owed;

    t_pcm_owed pcm_owed_q[$];
    t_pcm_owed oldest;
    int        fail_count = 0;
    int        checked    = 0;
    int        pending    = 0;

    assign o_fail_count = fail_count;
    assign o_checked    = checked;
    assign o_pending    = pending;

    // round(32767 * x / (1 + |x|)), ties away from zero, clamped to int16
    function automatic logic [OUT_W-1:0] soft_clip_to_pcm(input logic [IN_W-1:0] raw);
        logic               neg;
        logic [IN_W-1:0]    mag;
        logic [63:0]        den;
        logic [63:0]        num;
        logic [63:0]        quo;
        logic signed [31:0] pcm;
        neg = raw[IN_W-1];
        // -2^31 negates to itself, read back as unsigned 2^31
        mag = neg ? (~raw + 1'b1) : raw;
        den = (64'd1 << FRAC_BITS) + 64'(mag);
        num = 64'(2 * FULL_SCALE) * 64'(mag) + den;
        quo = num / (2 * den);
        if (quo > 64'd32768) begin
            quo = 64'd32768;
        end
        pcm = neg ? -32'(quo) : 32'(quo);
        if (pcm > 32767) begin
            pcm = 32767;
        end else if (pcm < -32768) begin
            pcm = -32768;
        end
        return pcm[OUT_W-1:0];
    endfunction

    // Print one line per mismatch (up to the cap) and count it
    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("[%0t] scq_stream_checker: %s", $time, what);
        end
    endtask

    // Compare output transactions first, then record new input transactions
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                if (pcm_owed_q.size() == 0) begin
                    report_mismatch($sformatf("output transaction %h/%b with nothing owed",
                                              i_m_tdata, i_m_tlast));
                end else begin
                    oldest = pcm_owed_q.pop_front();
                    checked++;
                    if (i_m_tdata !== oldest.pcm) begin
                        report_mismatch($sformatf("sample_in %h: pcm %h, want %h",
                                                  oldest.sample_in, i_m_tdata, oldest.pcm));
                    end
                    if (i_m_tlast !== oldest.last) begin
                        report_mismatch($sformatf("sample_in %h: last %b, want %b",
                                                  oldest.sample_in, i_m_tlast, oldest.last));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                pcm_owed_q.push_back('{sample_in: i_s_tdata,
                                       pcm:       soft_clip_to_pcm(i_s_tdata),
                                       last:      i_s_tlast});
            end
            pending <= pcm_owed_q.size();
        end
    end

endmodule

// ===== verif/tb_soft_clip_quantizer.sv =====
// Testbench top for the soft clip quantizer: clock, reset, sample stimulus
// with random gaps and back-pressure, and the final verdict.
// Depends on scq_pkg, soft_clip_quantizer and scq_stream_checker.
`timescale 1ns / 1ps

module tb_soft_clip_quantizer;
    import scq_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_SAMPLES = 1400;
    localparam int MAX_IDLE       = 8;
    localparam int MAX_BLOCK_LEN  = 48;
    localparam int HOLD_AT        = 500;
    localparam int PAUSE_AT       = 900;
    localparam int RX_HOLD_CYCLES = 64;
    localparam int HOLD_BURST     = 48;
    localparam int DRAIN_CYCLES   = 16;
    localparam int LIMIT_CYCLES   = 200000;
    localparam int N_CORNERS      = 20;

    // Corner samples: zero, +-1 LSB, full scale both ways, +-1.0 (an exact
    // rounding tie), +-0.5, just below and above 1.0, and bit patterns
    localparam logic [IN_W-1:0] CORNER_SAMPLES [N_CORNERS] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h8000_0001, 32'h0001_0000, 32'hFFFF_0000,
        32'h0000_8000, 32'hFFFF_8000, 32'h0000_FFFF, 32'h0001_0001,
        32'h0002_0000, 32'h4000_0000, 32'hC000_0000, 32'h7FFF_0000,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0002, 32'hFFFF_FFFE
    };

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             s_tlast  = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;

    int fail_count;
    int pcm_pending;
    int pcm_checked;
    int cycle_count  = 0;
    int samples_sent = 0;
    bit rx_eager     = 1'b0;
    bit rx_hold_req  = 1'b0;

    soft_clip_quantizer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    scq_stream_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pcm_pending),
        .o_checked    (pcm_checked)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d samples still owed",
                     cycle_count, pcm_pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one sample after an idle gap and wait for its transaction
    task automatic send_sample(input logic [IN_W-1:0] sample, input logic last,
                               input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        samples_sent++;
    endtask

    // Stop offering and wait until every owed sample has come back
    task automatic wait_all_returned();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pcm_pending != 0) @(posedge clk);
    endtask

    // Receiver: random stall before each transaction, one long hold on request
    initial begin : pcm_sink
        int stall;
        @(posedge clk iff rst_n);
        forever begin
            if (rx_hold_req) begin
                stall       = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end else begin
                stall = rx_eager ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // Stimulus and verdict
    initial begin : sample_source
        logic [IN_W-1:0] sample;
        logic [IN_W-1:0] mag;
        logic            last;
        int              block_len;
        int              kind;
        int              gap;
        int              rand_sent;
        int              blocks;
        int              hold_burst;
        bit              burst;
        bit              hold_done;
        bit              pause_done;
        rand_sent  = 0;
        blocks     = 0;
        hold_burst = 0;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners, tlast on every third one, the final one closing a block
        for (int i = 0; i < N_CORNERS; i++) begin
            send_sample(CORNER_SAMPLES[i], (i % 3 == 1) || (i == N_CORNERS - 1),
                        $urandom_range(0, MAX_IDLE));
        end
        wait_all_returned();

        // Random audio blocks; a few stray or missing tlast marks as noise
        while (rand_sent < RANDOM_SAMPLES) begin
            block_len = $urandom_range(1, MAX_BLOCK_LEN);
            burst     = ($urandom_range(0, 3) == 0);
            rx_eager  = ($urandom_range(0, 3) == 0);
            blocks++;
            for (int k = 0; k < block_len; k++) begin
                kind = $urandom_range(0, 99);
                if (kind < 30) begin
                    sample = $urandom();
                end else if (kind < 65) begin
                    // within about +-4.0
                    sample = $urandom_range(0, 1 << 19) - (1 << 18);
                end else if (kind < 80) begin
                    // around +-1.0, where rounding ties live
                    mag    = 32'h0001_0000 + $urandom_range(0, 512) - 256;
                    sample = $urandom_range(0, 1) ? -mag : mag;
                end else if (kind < 90) begin
                    sample = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 15)
                                                  : 32'h8000_0000 + $urandom_range(0, 15);
                end else begin
                    sample = $urandom_range(0, 16) - 8;
                end
                last = (k == block_len - 1);
                if ($urandom_range(0, 19) == 0) begin
                    last = ~last;
                end
                // Long receiver hold while the sender keeps pushing
                if (!hold_done && rand_sent >= HOLD_AT) begin
                    rx_hold_req = 1'b1;
                    hold_done   = 1'b1;
                    hold_burst  = HOLD_BURST;
                end
                gap = (burst || hold_burst > 0) ? 0 : $urandom_range(0, MAX_IDLE);
                if (hold_burst > 0) begin
                    hold_burst--;
                end
                send_sample(sample, last, gap);
                rand_sent++;
            end
            if (!pause_done && rand_sent >= PAUSE_AT) begin
                wait_all_returned();
                pause_done = 1'b1;
            end
        end

        wait_all_returned();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d samples in %0d random blocks plus %0d corners; %0d results checked.",
                 samples_sent, blocks, N_CORNERS, pcm_checked);
        $display("Random gaps and stalls, one %0d-cycle receiver hold, full drains %s",
                 RX_HOLD_CYCLES, "after the corners, mid-run and at the end.");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/scq_pkg.sv
src/scq_div_stage.sv
src/soft_clip_quantizer.sv
verif/scq_stream_checker.sv
verif/tb_soft_clip_quantizer.sv
